// ===== sv/qnlerp_pkg.sv =====
// Package: shared constants, state and operation types and the rounding helper for the quaternion nlerp core.
`timescale 1ns / 1ps
`default_nettype none
package qnlerp_pkg;

  localparam int COMPONENT_BITS_DEF   = 16;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;
  localparam int FRAC                 = 28;
  // Internal word: Q4.28 values plus headroom for intermediate terms
  localparam int IW                   = 36;

  localparam logic signed [IW-1:0] K_C0 = IW'(274189376);
  localparam logic signed [IW-1:0] K_C1 = IW'(257447312);
  localparam logic signed [IW-1:0] K_C2 = IW'(142946176);
  localparam logic signed [IW-1:0] K_T1 = IW'(245675344);
  localparam logic signed [IW-1:0] K_T2 = IW'(175052048);

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE, S_LERP, S_SUM, S_EST1, S_SQ, S_MV, S_TERM, S_MUL, S_SCALE, S_DONE
  } state_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_LERP, OP_SUM, OP_EST1, OP_SQ, OP_MV, OP_TERM, OP_MUL, OP_SCALE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] lane;
  } dp_cmd_t;

  typedef struct packed {
    logic le_t1;
    logic le_t2;
  } dp_stat_t;

  // Round half up a 72-bit product by FRAC bits, keep IW bits
  function automatic logic signed [IW-1:0] rnd28(input logic signed [71:0] p);
    logic signed [71:0] s;
    begin
      s = (p + 72'sd134217728) >>> FRAC;
      rnd28 = s[IW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/quaternion_nlerp_newton_rsqrt_core.sv =====
// Top level: quaternion nlerp with Newton-refined inverse square root.
`timescale 1ns / 1ps
`default_nettype none
// A transaction is taken when start is high and busy low; the result appears on
// the output ports for exactly one cycle with done high, and the receiver cannot
// stall it. The transaction takes longer with each further estimate step, since one
// shared 36x36 multiplier serves the datapath: each component, square and Newton
// product passes through it in turn. busy stays high until done and drops the cycle
// after, so a new transaction cannot be taken while one is still in progress.
module quaternion_nlerp_newton_rsqrt_core #(
  parameter int COMPONENT_BITS   = qnlerp_pkg::COMPONENT_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = qnlerp_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  output logic                            busy,
  output logic                            done,
  input  wire [WEIGHT_FRAC_BITS:0]        blend_weight,
  input  wire signed [COMPONENT_BITS-1:0] a_x, a_y, a_z, a_w,
  input  wire signed [COMPONENT_BITS-1:0] b_x, b_y, b_z, b_w,
  output logic signed [COMPONENT_BITS-1:0] out_x, out_y, out_z, out_w,
  output logic [1:0]                      refine_steps
);
  import qnlerp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  qnlerp_ctrl u_ctrl (
    .clk, .rst, .start, .stat, .busy, .done, .refine_steps, .cmd
  );

  qnlerp_dp #(
    .COMPONENT_BITS(COMPONENT_BITS), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_dp (
    .clk, .cmd, .blend_weight, .a_x, .a_y, .a_z, .a_w,
    .b_x, .b_y, .b_z, .b_w, .stat, .out_x, .out_y, .out_z, .out_w
  );

  // Steps reported with a result lie in one to three
  a_steps: assert property (@(posedge clk) disable iff (rst)
    done |-> (refine_steps == 2'd1 || refine_steps == 2'd2 || refine_steps == 2'd3))
    else $error("refine_steps out of range");
  // A result ends the transaction
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy after done");
  // Accepting a transaction raises busy
  a_accept: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accept without busy");
endmodule
`default_nettype wire

// ===== sv/qnlerp_dp.sv =====
// Datapath: lerp, squared length, inverse square root steps and output scaling.
`timescale 1ns / 1ps
`default_nettype none
module qnlerp_dp #(
  parameter int COMPONENT_BITS   = qnlerp_pkg::COMPONENT_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = qnlerp_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  wire                          clk,
  input  qnlerp_pkg::dp_cmd_t          cmd,
  input  wire [WEIGHT_FRAC_BITS:0]     blend_weight,
  input  wire signed [COMPONENT_BITS-1:0] a_x, a_y, a_z, a_w,
  input  wire signed [COMPONENT_BITS-1:0] b_x, b_y, b_z, b_w,
  output qnlerp_pkg::dp_stat_t         stat,
  output logic signed [COMPONENT_BITS-1:0] out_x, out_y, out_z, out_w
);
  import qnlerp_pkg::*;

  localparam int CB   = COMPONENT_BITS;
  localparam int WF   = WEIGHT_FRAC_BITS;
  localparam int UP   = (CB <= 30) ? 30 - CB : 0;
  localparam int DOWN = (CB > 30) ? CB - 30 : 0;
  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  logic [WF:0]             t;
  logic signed [CB-1:0]    a [4];
  logic signed [CB-1:0]    b [4];
  logic signed [CB:0]      q [4];
  logic signed [71:0]      sum;
  logic signed [IW-1:0]    v1, v2, x;
  logic signed [CB-1:0]    o [4];

  logic signed [CB:0]      la, lb, q_new;
  logic signed [CB+WF+2:0] prod;
  logic signed [CB+WF+2:0] rnd;
  logic signed [IW-1:0]    q28, mop_a, mop_b, mres, term;
  logic signed [71:0]      mprod;
  logic signed [IW-1:0]    r;

  // Shared lerp lane
  always_comb begin
    la   = {a[cmd.lane][CB-1], a[cmd.lane]};
    lb   = {b[cmd.lane][CB-1], b[cmd.lane]};
    prod = (CB+WF+3)'(lb - la) * $signed({2'b00, t});
    rnd  = (prod + (CB+WF+3)'(1 << (WF-1))) >>> WF;
    q_new = la + rnd[CB:0];
  end

  // Component scaled to 28 fractional bits
  always_comb begin
    if (DOWN == 0)
      q28 = IW'(q[cmd.lane]) <<< UP;
    else
      q28 = IW'((IW'(q[cmd.lane]) + IW'(1 << ((DOWN > 0) ? DOWN - 1 : 0))) >>> DOWN);
  end

  // Shared multiplier, one product a cycle
  always_comb begin
    mop_a = x;
    mop_b = x;
    unique case (cmd.op)
      OP_SUM:   begin mop_a = q28;  mop_b = q28; end
      OP_EST1:  begin mop_a = v1 - K_C1; mop_b = K_C2; end
      OP_SQ:    begin mop_a = v2;   mop_b = v2; end
      OP_MV:    begin mop_a = x;    mop_b = v1; end
      OP_TERM:  begin mop_a = x - K_C1; mop_b = K_C2; end
      OP_MUL:   begin mop_a = x;    mop_b = v2; end
      OP_SCALE: begin mop_a = IW'(q[cmd.lane]); mop_b = v2; end
      default:  begin mop_a = x;    mop_b = x; end
    endcase
    mprod = 72'(mop_a) * 72'(mop_b);
    mres  = rnd28(mprod);
    term  = K_C0 - mres;
    r     = mres;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        t    <= (blend_weight > (WF+1)'(1 << WF)) ? (WF+1)'(1 << WF) : blend_weight;
        a[0] <= a_x; a[1] <= a_y; a[2] <= a_z; a[3] <= a_w;
        b[0] <= b_x; b[1] <= b_y; b[2] <= b_z; b[3] <= b_w;
        sum  <= '0;
      end
      OP_LERP: q[cmd.lane] <= q_new;
      OP_SUM: begin
        if (cmd.lane == 2'd3)
          v1 <= rnd28(sum + mprod);
        else
          sum <= sum + mprod;
      end
      OP_EST1:  v2 <= term;
      OP_SQ:    x  <= mres;
      OP_MV:    x  <= mres;
      OP_TERM:  x  <= term;
      OP_MUL:   v2 <= mres;
      OP_SCALE: begin
        if (r > IW'(CMAX))      o[cmd.lane] <= CMAX;
        else if (r < IW'(CMIN)) o[cmd.lane] <= CMIN;
        else                    o[cmd.lane] <= r[CB-1:0];
      end
      default: ;
    endcase
  end

  assign stat.le_t1 = (v1 <= K_T1);
  assign stat.le_t2 = (v1 <= K_T2);
  assign out_x = o[0];
  assign out_y = o[1];
  assign out_z = o[2];
  assign out_w = o[3];
endmodule
`default_nettype wire

// ===== sv/qnlerp_ctrl.sv =====
// Controller: sequences the datapath through load, lerp, sum, estimate, Newton refinement and scale.
`timescale 1ns / 1ps
`default_nettype none
module qnlerp_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  qnlerp_pkg::dp_stat_t stat,
  output logic                 busy,
  output logic                 done,
  output logic [1:0]           refine_steps,
  output qnlerp_pkg::dp_cmd_t  cmd
);
  import qnlerp_pkg::*;

  state_t     state, state_next;
  logic [1:0] lane, lane_next;
  logic [1:0] pass, pass_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lane  <= '0;
      pass  <= '0;
    end else begin
      state <= state_next;
      lane  <= lane_next;
      pass  <= pass_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    lane_next  = lane;
    pass_next  = pass;
    unique case (state)
      S_IDLE: if (start) begin state_next = S_LERP; lane_next = '0; end
      S_LERP: begin
        lane_next = lane + 2'd1;
        if (lane == 2'd3) state_next = S_SUM;
      end
      S_SUM: begin
        lane_next = lane + 2'd1;
        if (lane == 2'd3) state_next = S_EST1;
      end
      S_EST1: begin
        pass_next = 2'd1;
        state_next = stat.le_t1 ? S_SQ : S_SCALE;
        lane_next = '0;
      end
      S_SQ:   state_next = S_MV;
      S_MV:   state_next = S_TERM;
      S_TERM: state_next = S_MUL;
      S_MUL: begin
        pass_next = pass + 2'd1;
        lane_next = '0;
        state_next = (pass == 2'd1 && stat.le_t2) ? S_SQ : S_SCALE;
      end
      S_SCALE: begin
        lane_next = lane + 2'd1;
        if (lane == 2'd3) state_next = S_DONE;
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd.lane = lane;
    cmd.op   = OP_NONE;
    busy     = (state != S_IDLE);
    done     = (state == S_DONE);
    unique case (state)
      S_IDLE:  cmd.op = start ? OP_LOAD : OP_NONE;
      S_LERP:  cmd.op = OP_LERP;
      S_SUM:   cmd.op = OP_SUM;
      S_EST1:  cmd.op = OP_EST1;
      S_SQ:    cmd.op = OP_SQ;
      S_MV:    cmd.op = OP_MV;
      S_TERM:  cmd.op = OP_TERM;
      S_MUL:   cmd.op = OP_MUL;
      S_SCALE: cmd.op = OP_SCALE;
      default: cmd.op = OP_NONE;
    endcase
  end

  assign refine_steps = pass;
endmodule
`default_nettype wire
